// ----- src/cle_pkg.sv -----
// package: shared types and constants for the circular list engine
`timescale 1ns / 1ps
package cle_pkg;
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_INS_HD = 3'd1;
    localparam logic [2:0] OP_INS_TL = 3'd2;
    localparam logic [2:0] OP_INS_AF = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;
    localparam logic [2:0] OP_LIST   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_CHK, S_LINK, S_OUT
    } t_state;

    // command bundle from controller to datapath
    typedef struct packed {
        logic       load;     // capture input item
        logic       start;    // start new list
        logic       alloc;    // take a node, write its value and forward link
        logic       splice;   // point the predecessor link at the new node
        logic       rd_cur;   // issue read of cur node
        logic       step;     // advance cur along the list
        logic       del;      // delete cur
        logic       emit_el;  // result carries cur value
        logic [1:0] status;
        logic       fin;
        logic       out_load; // load output register
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       match;    // cur value equals search value
        logic       last;     // walk index at final node
        logic       out_busy; // output register holds a result the receiver is not taking
    } t_sts;
endpackage

// ----- src/cle_if.sv -----
// interfaces: valid/ready channels for items and results
`timescale 1ns / 1ps
interface cle_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] new_value;
    logic signed [31:0] anchor_key;
    modport source (output valid, op, new_value, anchor_key, input ready);
    modport sink   (input valid, op, new_value, anchor_key, output ready);
endinterface

interface cle_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               final_res;
    logic [6:0]         occupancy;
    modport source (output valid, element, status, final_res, occupancy, input ready);
    modport sink   (input valid, element, status, final_res, occupancy, output ready);
endinterface

// ----- src/cle_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/cle_datapath.sv -----
// datapath: node memories, free stack, pointers and output register
`timescale 1ns / 1ps
module cle_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cle_pkg::t_cmd  i_cmd,
    output cle_pkg::t_sts  o_sts,
    input  logic [2:0]     i_op,
    input  logic [31:0]    i_new_value,
    input  logic [31:0]    i_anchor_key,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_element,
    output logic [1:0]     o_status,
    output logic           o_final,
    output logic [6:0]     o_occupancy
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [2:0]    r_op;
    logic [31:0]   r_val, r_key;
    logic [AW-1:0] r_tail, r_head, r_cur, r_prev, r_new;
    logic [CW-1:0] r_count, r_idx, r_fresh, r_nfree;
    logic          r_valid;
    logic [31:0]   r_element;
    logic [1:0]    r_status;
    logic          r_final;
    logic [6:0]    r_occ;

    logic          is_af;
    logic [AW-1:0] n_new;
    logic [31:0]   val_rd;
    logic [AW-1:0] link_rd, free_rd;
    logic          val_we, link_we;
    logic [AW-1:0] val_wa, link_wa, link_wd;
    logic [AW-1:0] free_wa, free_ra;
    logic [31:0]   cmp_val;

    cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_vals (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(r_val),
        .i_raddr(r_cur), .o_rdata(val_rd)
    );

    cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(r_cur), .o_rdata(link_rd)
    );

    cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
        .i_clk(i_clk), .i_we(i_cmd.del), .i_waddr(free_wa), .i_wdata(r_cur),
        .i_raddr(free_ra), .o_rdata(free_rd)
    );

    assign is_af = (r_op == cle_pkg::OP_INS_AF);
    // nodes never handed out since the last start come from r_fresh, freed ones from the stack
    assign n_new   = (r_nfree != '0) ? free_rd : AW'(r_fresh);
    assign free_wa = AW'(r_nfree);
    assign free_ra = AW'(r_nfree - CW'(1));

    assign val_we  = i_cmd.start | i_cmd.alloc;
    assign val_wa  = i_cmd.start ? '0 : n_new;
    assign link_we = i_cmd.start | i_cmd.alloc | i_cmd.splice | i_cmd.del;

    always_comb begin
        if (i_cmd.start) begin
            link_wa = '0;
            link_wd = '0;
        end else if (i_cmd.alloc) begin
            link_wa = n_new;
            link_wd = is_af ? link_rd : r_head;
        end else if (i_cmd.splice) begin
            link_wa = is_af ? r_cur : r_tail;
            link_wd = r_new;
        end else begin
            // delete: prev skips over cur
            link_wa = r_prev;
            link_wd = link_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail  <= '0;
            r_head  <= '0;
            r_cur   <= '0;
            r_count <= '0;
            r_fresh <= '0;
            r_nfree <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op  <= i_op;
                r_val <= i_new_value;
                r_key <= i_anchor_key;
            end
            if (i_cmd.start) begin
                r_tail  <= '0;
                r_head  <= '0;
                r_count <= CW'(1);
                r_fresh <= CW'(1);
                r_nfree <= '0;
            end
            if (i_cmd.alloc) begin
                r_new   <= n_new;
                r_count <= r_count + CW'(1);
                if (r_nfree != '0) begin
                    r_nfree <= r_nfree - CW'(1);
                end else begin
                    r_fresh <= r_fresh + CW'(1);
                end
            end
            if (i_cmd.splice) begin
                if (is_af) begin
                    if (r_cur == r_tail) begin
                        r_tail <= r_new;
                    end
                end else if (r_op == cle_pkg::OP_INS_HD) begin
                    r_head <= r_new;
                end else begin
                    r_tail <= r_new;
                end
            end
            if (i_cmd.del) begin
                if (r_count == CW'(1)) begin
                    r_tail <= '0;
                end else begin
                    if (r_cur == r_head) begin
                        r_head <= link_rd;
                    end
                    if (r_cur == r_tail) begin
                        r_tail <= r_prev;
                    end
                end
                r_nfree <= r_nfree + CW'(1);
                r_count <= r_count - CW'(1);
            end
            // walk pointers: rd_cur starts at head
            if (i_cmd.rd_cur) begin
                r_prev <= r_tail;
                r_cur  <= r_head;
                r_idx  <= '0;
            end
            if (i_cmd.step) begin
                r_prev <= r_cur;
                r_cur  <= link_rd;
                r_idx  <= r_idx + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload; out_load comes after any count update of the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_element <= i_cmd.emit_el ? val_rd : 32'd0;
            r_status  <= i_cmd.status;
            r_final   <= i_cmd.fin;
            r_occ     <= 7'(r_count);
        end
    end

    assign cmp_val = is_af ? r_key : r_val;

    assign o_sts.op       = r_op;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count >= CW'(CAPACITY));
    assign o_sts.match    = (val_rd == cmp_val);
    assign o_sts.last     = (r_idx + CW'(1) == r_count);
    assign o_sts.out_busy = r_valid & ~i_ready;

    assign o_valid     = r_valid;
    assign o_element   = r_element;
    assign o_status    = r_status;
    assign o_final     = r_final;
    assign o_occupancy = r_occ;
endmodule

// ----- src/cle_ctrl.sv -----
// controller: sequences each operation over the datapath
`timescale 1ns / 1ps
module cle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cle_pkg::t_sts  i_sts,
    output cle_pkg::t_cmd  o_cmd
);
    cle_pkg::t_state r_state, n_state;
    logic [1:0] r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::S_IDLE;
            r_st    <= cle_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            cle_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = cle_pkg::S_DISPATCH;
                end
            end
            cle_pkg::S_DISPATCH: begin
                n_st    = cle_pkg::ST_OK;
                n_state = cle_pkg::S_OUT;
                case (i_sts.op)
                    cle_pkg::OP_START: o_cmd.start = 1'b1;
                    cle_pkg::OP_INS_HD, cle_pkg::OP_INS_TL, cle_pkg::OP_INS_AF: begin
                        if (i_sts.empty) begin
                            o_cmd.start = 1'b1;
                        end else if (i_sts.full) begin
                            n_st = cle_pkg::ST_FULL;
                        end else if (i_sts.op == cle_pkg::OP_INS_AF) begin
                            o_cmd.rd_cur = 1'b1;
                            n_state = cle_pkg::S_WALK_RD;
                        end else begin
                            o_cmd.alloc = 1'b1;
                            n_state = cle_pkg::S_LINK;
                        end
                    end
                    cle_pkg::OP_DELETE, cle_pkg::OP_LIST: begin
                        if (i_sts.empty) begin
                            n_st = cle_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_cur = 1'b1;
                            n_state = cle_pkg::S_WALK_RD;
                        end
                    end
                    default: ;
                endcase
            end
            // wait state for the registered node ram read
            cle_pkg::S_WALK_RD: n_state = cle_pkg::S_WALK_CHK;
            cle_pkg::S_WALK_CHK: begin
                if (i_sts.op == cle_pkg::OP_LIST) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.emit_el  = 1'b1;
                        o_cmd.fin      = i_sts.last;
                        o_cmd.status   = cle_pkg::ST_OK;
                        if (i_sts.last) begin
                            n_state = cle_pkg::S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state = cle_pkg::S_WALK_RD;
                        end
                    end
                end else if (i_sts.match) begin
                    n_st = cle_pkg::ST_OK;
                    if (i_sts.op == cle_pkg::OP_INS_AF) begin
                        o_cmd.alloc = 1'b1;
                        n_state = cle_pkg::S_LINK;
                    end else begin
                        o_cmd.del = 1'b1;
                        n_state = cle_pkg::S_OUT;
                    end
                end else if (i_sts.last) begin
                    n_st = cle_pkg::ST_NOT_FND;
                    n_state = cle_pkg::S_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = cle_pkg::S_WALK_RD;
                end
            end
            // second link write of an insert
            cle_pkg::S_LINK: begin
                o_cmd.splice = 1'b1;
                n_state = cle_pkg::S_OUT;
            end
            cle_pkg::S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.status   = r_st;
                    o_cmd.fin      = 1'b1;
                    n_state = cle_pkg::S_IDLE;
                end
            end
            default: n_state = cle_pkg::S_IDLE;
        endcase
    end
endmodule

// ----- src/circular_list_engine.sv -----
// top level: circular singly linked list engine
`timescale 1ns / 1ps
// usage
// in_ch carries one operation per transfer (op, new_value, anchor_key);
// out_ch returns results (element, status, final_res, occupancy).
// one item is worked at a time; ready is high only while the engine is idle,
// which it is again the cycle after the item's last result is loaded.
// start, unknown op and rejected inserts: dispatch, then the result is loaded;
// head/tail insert: node write, then the old tail's link write, then the result.
// insert-after and delete walk the list (ram read, then compare, per node).
// list-all streams one result per node, loaded at the node's compare step, the
// last one marked with final_res; an empty list
// gives one result with status empty.
// a single output register holds each result; when the receiver stalls
// the walk waits on that register, nothing is dropped.
// reset (synchronous, active low) empties the list and clears the free-node
// counters; node memories are not cleared.
module circular_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cle_in_if.sink      in_ch,
    cle_out_if.source   out_ch
);
    cle_pkg::t_cmd cmd;
    cle_pkg::t_sts sts;

    cle_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    cle_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_op(in_ch.op), .i_new_value(in_ch.new_value), .i_anchor_key(in_ch.anchor_key),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_element(out_ch.element),
        .o_status(out_ch.status), .o_final(out_ch.final_res),
        .o_occupancy(out_ch.occupancy)
    );

`ifndef NO_ASSERTIONS
    // never accept an item while a result transfer is still pending in the walk
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.ready |-> !(cmd.out_load)))
        else $error("accept during output load");
    // occupancy never exceeds capacity
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid |-> out_ch.occupancy <= 7'(CAPACITY)))
        else $error("occupancy out of range");
    // non-list results never carry an element
    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && !cmd.emit_el |=> out_ch.element == 32'd0))
        else $error("element not zero");
`endif
endmodule

// ----- tb/sv/circular_list_engine_test.sv -----
// testbench: circular list engine checked against a behavioral list predictor
`timescale 1ns / 1ps
module circular_list_engine_test;
    localparam int CAP = 64;

    typedef struct packed {
        logic signed [31:0] element;
        logic [1:0]         status;
        logic               final_res;
        logic [6:0]         occupancy;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    cle_in_if  in_ch ();
    cle_out_if out_ch ();

    circular_list_engine #(.CAPACITY(CAP)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state: list contents head to tail
    logic signed [31:0] list_vals[$];
    t_result            pending_results[$];
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 fail_count;

    function automatic t_result mk(logic signed [31:0] e, logic [1:0] s, logic f);
        t_result r;
        r.element   = e;
        r.status    = s;
        r.final_res = f;
        r.occupancy = 7'(list_vals.size());
        return r;
    endfunction

    function automatic int find_value(logic signed [31:0] v);
        foreach (list_vals[i]) begin
            if (list_vals[i] == v) return i;
        end
        return -1;
    endfunction

    task automatic predict_list_op(logic [2:0] op, logic signed [31:0] v,
                                   logic signed [31:0] k);
        logic [1:0] st;
        int         idx;
        st = cle_pkg::ST_OK;
        if ((op == cle_pkg::OP_INS_HD || op == cle_pkg::OP_INS_TL ||
             op == cle_pkg::OP_INS_AF) && list_vals.size() == 0) begin
            op = cle_pkg::OP_START;
        end else if ((op == cle_pkg::OP_INS_HD || op == cle_pkg::OP_INS_TL ||
                      op == cle_pkg::OP_INS_AF) && list_vals.size() >= CAP) begin
            pending_results.push_back(mk(0, cle_pkg::ST_FULL, 1'b1));
            return;
        end
        case (op)
            cle_pkg::OP_START: begin
                list_vals.delete();
                list_vals.push_back(v);
            end
            cle_pkg::OP_INS_HD: list_vals.push_front(v);
            cle_pkg::OP_INS_TL: list_vals.push_back(v);
            cle_pkg::OP_INS_AF: begin
                idx = find_value(k);
                if (idx < 0) st = cle_pkg::ST_NOT_FND;
                else list_vals.insert(idx + 1, v);
            end
            cle_pkg::OP_DELETE: begin
                if (list_vals.size() == 0) begin
                    st = cle_pkg::ST_EMPTY;
                end else begin
                    idx = find_value(v);
                    if (idx < 0) st = cle_pkg::ST_NOT_FND;
                    else list_vals.delete(idx);
                end
            end
            cle_pkg::OP_LIST: begin
                if (list_vals.size() == 0) begin
                    pending_results.push_back(mk(0, cle_pkg::ST_EMPTY, 1'b1));
                end else begin
                    foreach (list_vals[i]) begin
                        pending_results.push_back(mk(list_vals[i], cle_pkg::ST_OK,
                                                     i == list_vals.size() - 1));
                    end
                end
                return;
            end
            default: ;
        endcase
        pending_results.push_back(mk(0, st, 1'b1));
    endtask

    // valid stays high after a transfer until the next send or drain updates it
    task automatic send_op(logic [2:0] op, logic signed [31:0] v, logic signed [31:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.new_value  <= v;
        in_ch.anchor_key <= k;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_list_op(op, v, k);
    endtask

    // receiver stall and result checking
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result element=%0d", out_ch.element);
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (out_ch.element !== exp_r.element) begin
                        $error("element exp %0d got %0d", exp_r.element, out_ch.element);
                        fail_count++;
                    end
                    if (out_ch.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, out_ch.status);
                        fail_count++;
                    end
                    if (out_ch.final_res !== exp_r.final_res) begin
                        $error("final_res exp %0d got %0d", exp_r.final_res,
                               out_ch.final_res);
                        fail_count++;
                    end
                    if (out_ch.occupancy !== exp_r.occupancy) begin
                        $error("occupancy exp %0d got %0d", exp_r.occupancy,
                               out_ch.occupancy);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] pick_value();
        // mostly small values so keys hit, sometimes full range
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($urandom_range(15)) - 8;
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (list_vals.size() != 0 && $urandom_range(3) != 0)
            return list_vals[$urandom_range(list_vals.size() - 1)];
        return pick_value();
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_op(cle_pkg::OP_LIST, 0, 0);
        send_op(cle_pkg::OP_DELETE, 5, 0);
        send_op(cle_pkg::OP_INS_HD, 32'sh7fffffff, 0);
        send_op(cle_pkg::OP_INS_TL, 32'sh80000000, 0);
        send_op(cle_pkg::OP_INS_AF, 32'shffffffff, 32'sh7fffffff);
        send_op(cle_pkg::OP_INS_AF, 1, 32'sh80000000);
        send_op(cle_pkg::OP_INS_AF, 2, 12345);
        send_op(cle_pkg::OP_LIST, 0, 0);
        send_op(cle_pkg::OP_DELETE, 99, 0);
        send_op(cle_pkg::OP_DELETE, 1, 0);
        send_op(cle_pkg::OP_DELETE, 32'sh7fffffff, 0);
        send_op(cle_pkg::OP_LIST, 0, 0);
        send_op(3'd6, 1, 1);
        send_op(3'd7, 2, 2);
        send_op(cle_pkg::OP_START, 32'sh55555555, 32'shaaaaaaaa);
        send_op(cle_pkg::OP_DELETE, 32'sh55555555, 0);
        send_op(cle_pkg::OP_INS_AF, 3, 3);
        send_op(cle_pkg::OP_LIST, 0, 0);
        drain();
    endtask

    task automatic test_fill_full();
        send_op(cle_pkg::OP_START, 0, 0);
        for (int i = 1; i < CAP; i++) send_op(cle_pkg::OP_INS_TL, i, 0);
        send_op(cle_pkg::OP_INS_HD, -1, 0);
        send_op(cle_pkg::OP_INS_TL, -2, 0);
        send_op(cle_pkg::OP_INS_AF, -3, 99999);
        send_op(cle_pkg::OP_LIST, 0, 0);
        send_op(cle_pkg::OP_DELETE, 63, 0);
        send_op(cle_pkg::OP_INS_AF, -4, 62);
        send_op(cle_pkg::OP_LIST, 0, 0);
        drain();
    endtask

    task automatic test_random(int n_items);
        logic [2:0] op;
        int         r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 3) op = cle_pkg::OP_START;
            else if (r < 20) op = cle_pkg::OP_INS_HD;
            else if (r < 40) op = cle_pkg::OP_INS_TL;
            else if (r < 60) op = cle_pkg::OP_INS_AF;
            else if (r < 82) op = cle_pkg::OP_DELETE;
            else if (r < 97) op = cle_pkg::OP_LIST;
            else op = 3'($urandom_range(7, 6));
            send_op(op, (op == cle_pkg::OP_DELETE) ? pick_key() : pick_value(), pick_key());
        end
        drain();
    endtask

    initial begin
        fail_count       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = cle_pkg::OP_START;
        in_ch.new_value  = '0;
        in_ch.anchor_key = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_full();
        test_random(72);
        send_idle_pct = 45;
        test_random(72);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        test_random(72);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        test_random(72);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
